// ===== rtl/ipc_pkg.sv =====
// Shared constants and codes for the interrupt priority controller.
package ipc_pkg;

   // Default sizing of the controller.
   localparam int NUM_SOURCES_DEF   = 14;
   localparam int PRIORITY_BITS_DEF = 3;

   // Fixed field widths of the request word and the register port.
   localparam int OP_W      = 2;
   localparam int CID_W     = 5;
   localparam int REG_IDX_W = 2;

   // Operation codes carried in a request word.
   localparam logic [OP_W-1:0] OP_NONE     = 2'd0;
   localparam logic [OP_W-1:0] OP_CLAIM    = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPLETE = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [REG_IDX_W-1:0] REG_PRIORITY  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_ENABLE    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

endpackage

// ===== rtl/interrupt_priority_controller.sv =====
// Platform-level interrupt controller for one hart: gateways, claim and completion.
//
//   Channel | Direction | Handshake              | Word contents
//   req     | in        | req_valid / req_ready  | operation, source_lines, complete_id
//   rsp     | out       | rsp_valid / rsp_ready  | claim_id, external_irq, pending_view
//   csr     | in        | csr_write_en           | csr_index, csr_wdata (no read-back)
//
// A request word is captured in an input register and is resolved once the result register
// is free; one word per cycle is sustained while rsp_ready stays high, and the response
// is held in the result register until it is taken. The priority pick over all sources
// is one pass of level detection and a lowest-ID select. Reset is synchronous and clears
// pending, in-service and configuration state. A stalled response holds the
// resolve stage, and the input register then fills and drops req_ready.
module interrupt_priority_controller #(
   parameter int NUM_SOURCES   = ipc_pkg::NUM_SOURCES_DEF,
   parameter int PRIORITY_BITS = ipc_pkg::PRIORITY_BITS_DEF,
   localparam int SRC_W  = NUM_SOURCES + 1,
   localparam int ID_W   = $clog2(NUM_SOURCES + 1),
   localparam int PT_W   = NUM_SOURCES * PRIORITY_BITS,
   localparam int CSR_W  = (PT_W > SRC_W) ? PT_W : SRC_W
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ipc_pkg::OP_W-1:0]      req_operation,
   input  logic [SRC_W-1:0]              req_source_lines,
   input  logic [ipc_pkg::CID_W-1:0]     req_complete_id,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ID_W-1:0]               rsp_claim_id,
   output logic                          rsp_external_irq,
   output logic [SRC_W-1:0]              rsp_pending_view,
   // Configuration port
   input  logic                          csr_write_en,
   input  logic [ipc_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]              csr_wdata
);
   import ipc_pkg::*;

   localparam int NUM_LEVELS = 2 ** PRIORITY_BITS;

   // Configuration registers
   logic [PT_W-1:0]          priority_ff;
   logic [SRC_W-1:0]         enable_ff;
   logic [PRIORITY_BITS-1:0] threshold_ff;

   // Interrupt state
   logic [SRC_W-1:0] pending_ff, pending_in;
   logic [SRC_W-1:0] in_service_ff, in_service_in;

   // Input register
   logic             s1_valid_ff;
   logic [OP_W-1:0]  s1_op_ff;
   logic [SRC_W-1:0] s1_lines_ff;
   logic [CID_W-1:0] s1_cid_ff;

   // Result register
   logic             rsp_valid_ff;
   logic [ID_W-1:0]  claim_id_ff, claim_id_in;
   logic             irq_ff, irq_in;
   logic [SRC_W-1:0] pend_view_ff;

   // Resolve-stage signals
   logic                     advance;
   logic [SRC_W-1:0]         src_mask;
   logic [PRIORITY_BITS-1:0] src_prio [SRC_W];
   logic [SRC_W-1:0]         above_mask;
   logic [SRC_W-1:0]         pend_gated;
   logic [SRC_W-1:0]         qualified;
   logic [NUM_LEVELS-1:0]    level_hit;
   logic [PRIORITY_BITS-1:0] best_level;
   logic [SRC_W-1:0]         best_set;
   logic [SRC_W-1:0]         winner;
   logic                     claim_hit;
   logic [SRC_W-1:0]         complete_mask;

   // The resolve stage moves when it holds a word and the result register is free.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // Per-source priority, threshold compare and complete-ID decode.
   always_comb begin
      src_mask      = '0;
      above_mask    = '0;
      complete_mask = '0;
      src_prio[0]   = '0;
      for (int n = 1; n <= NUM_SOURCES; n++) begin
         src_mask[n]      = 1'b1;
         src_prio[n]      = priority_ff[(n-1)*PRIORITY_BITS +: PRIORITY_BITS];
         above_mask[n]    = src_prio[n] > threshold_ff;
         complete_mask[n] = s1_cid_ff == CID_W'(n);
      end
   end

   // Level gateways, then the set of sources that may be claimed.
   assign pend_gated = pending_ff | (s1_lines_ff & src_mask & ~in_service_ff);
   assign qualified  = pend_gated & enable_ff & above_mask;

   // Find the highest priority level present among qualified sources.
   always_comb begin
      level_hit = '0;
      for (int n = 1; n <= NUM_SOURCES; n++) begin
         for (int p = 0; p < NUM_LEVELS; p++) begin
            if (qualified[n] && (src_prio[n] == PRIORITY_BITS'(p))) begin
               level_hit[p] = 1'b1;
            end
         end
      end
      best_level = '0;
      for (int p = 0; p < NUM_LEVELS; p++) begin
         if (level_hit[p]) begin
            best_level = PRIORITY_BITS'(p);
         end
      end
   end

   // Among sources at the best level, the lowest ID wins.
   always_comb begin
      best_set = '0;
      for (int n = 1; n <= NUM_SOURCES; n++) begin
         best_set[n] = qualified[n] && (src_prio[n] == best_level);
      end
   end

   assign winner    = best_set & (~best_set + SRC_W'(1));
   assign claim_hit = (s1_op_ff == OP_CLAIM) && (qualified != '0);

   // Next state and result fields.
   always_comb begin
      pending_in    = pend_gated;
      in_service_in = in_service_ff;
      claim_id_in   = '0;
      case (s1_op_ff)
         OP_CLAIM: begin
            if (claim_hit) begin
               pending_in    = pend_gated & ~winner;
               in_service_in = in_service_ff | winner;
               for (int n = 1; n <= NUM_SOURCES; n++) begin
                  if (winner[n]) begin
                     claim_id_in = claim_id_in | ID_W'(n);
                  end
               end
            end
         end
         OP_COMPLETE: begin
            in_service_in = in_service_ff & ~(complete_mask & enable_ff);
         end
         default: begin
         end
      endcase
      irq_in = (pending_in & enable_ff & above_mask) != '0;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         priority_ff  <= '0;
         enable_ff    <= '0;
         threshold_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_PRIORITY:  priority_ff  <= csr_wdata[PT_W-1:0];
            REG_ENABLE:    enable_ff    <= csr_wdata[SRC_W-1:0] & src_mask;
            REG_THRESHOLD: threshold_ff <= csr_wdata[PRIORITY_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register and its valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_op_ff    <= req_operation;
         s1_lines_ff <= req_source_lines;
         s1_cid_ff   <= req_complete_id;
      end
   end

   // Interrupt state and result register, updated as a word is resolved.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         in_service_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            pending_ff    <= pending_in;
            in_service_ff <= in_service_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
      if (advance) begin
         claim_id_ff  <= claim_id_in;
         irq_ff       <= irq_in;
         pend_view_ff <= pending_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_claim_id     = claim_id_ff;
   assign rsp_external_irq = irq_ff;
   assign rsp_pending_view = pend_view_ff;

   // A source is never pending and in service at the same time.
   a_pend_service_disjoint: assert property (@(posedge clock) disable iff (reset)
      (pending_ff & in_service_ff) == '0)
      else $error("source both pending and in service");

   // Bit 0 never carries state.
   a_bit0_clear: assert property (@(posedge clock) disable iff (reset)
      !pending_ff[0] && !in_service_ff[0])
      else $error("state set for source 0");

   // A successful claim adds exactly one in-service source.
   a_claim_one: assert property (@(posedge clock) disable iff (reset)
      advance && claim_hit |=>
         $countones(in_service_ff) == $countones($past(in_service_ff)) + 1)
      else $error("claim did not mark exactly one source in service");

   // Interrupt state only changes when a word is resolved.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pending_ff) && $stable(in_service_ff))
      else $error("interrupt state changed without a resolved word");

endmodule

// ===== dv/ipc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the interrupt priority controller: predicts each response word and compares it.
module ipc_checker #(
   parameter int NUM_SRC = ipc_pkg::NUM_SOURCES_DEF,
   parameter int PRI_W   = ipc_pkg::PRIORITY_BITS_DEF,
   localparam int SRC_W  = NUM_SRC + 1,
   localparam int ID_W   = $clog2(NUM_SRC + 1),
   localparam int PT_W   = NUM_SRC * PRI_W,
   localparam int CSR_W  = (PT_W > SRC_W) ? PT_W : SRC_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [ipc_pkg::OP_W-1:0]      req_operation,
   input  logic [SRC_W-1:0]              req_source_lines,
   input  logic [ipc_pkg::CID_W-1:0]     req_complete_id,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [ID_W-1:0]               rsp_claim_id,
   input  logic                          rsp_external_irq,
   input  logic [SRC_W-1:0]              rsp_pending_view,
   input  logic                          csr_write_en,
   input  logic [ipc_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]              csr_wdata,
   output int                            error_count,
   output int                            words_in_flight
);
   import ipc_pkg::*;

   // Bit 0 is not a source, so it never holds pending or in-service state.
   localparam logic [SRC_W-1:0] SOURCE_MASK = {{NUM_SRC{1'b1}}, 1'b0};

   typedef struct packed {
      logic [ID_W-1:0]  claim_id;
      logic             external_irq;
      logic [SRC_W-1:0] pending_view;
   } irq_word_type;

   // Shadow copy of the controller's registers and gateway state.
   logic [PT_W-1:0]  priority_reg;
   logic [SRC_W-1:0] enable_reg;
   logic [PRI_W-1:0] threshold_reg;
   logic [SRC_W-1:0] pending_bits;
   logic [SRC_W-1:0] in_service_bits;
   irq_word_type     expected_words[$];
   int               mismatches;

   // Highest-priority enabled pending source above the threshold; lowest ID wins a tie.
   function automatic logic [ID_W-1:0] top_source(input logic [SRC_W-1:0] pend);
      logic [SRC_W-1:0] cand;
      logic [ID_W-1:0]  best;
      logic [PRI_W-1:0] best_level;
      logic [PRI_W-1:0] level;
      int               n;
      cand       = pend & enable_reg & SOURCE_MASK;
      best       = '0;
      best_level = '0;
      for (n = 1; n <= NUM_SRC; n++) begin
         level = priority_reg[PRI_W*(n-1) +: PRI_W];
         if (cand[n] && level > threshold_reg && level > best_level) begin
            best       = ID_W'(n);
            best_level = level;
         end
      end
      return best;
   endfunction

   // Apply one request word to the shadow state and queue the response it must produce.
   task automatic resolve_request(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] lines,
                                  input logic [CID_W-1:0] cid);
      irq_word_type    w;
      logic [ID_W-1:0] won;
      // Level gateways sample first; a source in service is not resampled.
      pending_bits = (pending_bits | (lines & ~in_service_bits)) & SOURCE_MASK;
      won = '0;
      case (op)
         OP_CLAIM: begin
            won = top_source(pending_bits);
            if (won != '0) begin
               pending_bits[won]    = 1'b0;
               in_service_bits[won] = 1'b1;
            end
         end
         OP_COMPLETE: begin
            // Out-of-range or disabled IDs leave the in-service bits alone.
            if (cid >= 1 && cid <= NUM_SRC && enable_reg[cid])
               in_service_bits[cid] = 1'b0;
         end
         default: ;
      endcase
      w.claim_id     = won;
      w.external_irq = (top_source(pending_bits) != '0);
      w.pending_view = pending_bits;
      expected_words.push_back(w);
   endtask

   // Track register writes, predict on each accepted request, compare each accepted response.
   always @(posedge clock) begin : monitor
      irq_word_type want;
      if (reset) begin
         priority_reg    = '0;
         enable_reg      = '0;
         threshold_reg   = '0;
         pending_bits    = '0;
         in_service_bits = '0;
         mismatches      = 0;
         expected_words.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_PRIORITY:  priority_reg  = csr_wdata[PT_W-1:0];
               REG_ENABLE:    enable_reg    = csr_wdata[SRC_W-1:0];
               REG_THRESHOLD: threshold_reg = csr_wdata[PRI_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            resolve_request(req_operation, req_source_lines, req_complete_id);
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: response word with nothing expected (claim_id %0d)",
                        $time, rsp_claim_id);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_claim_id !== want.claim_id) begin
                  $display("%0t: claim_id expected %0d, actual %0d",
                           $time, want.claim_id, rsp_claim_id);
                  mismatches++;
               end
               if (rsp_external_irq !== want.external_irq) begin
                  $display("%0t: external_irq expected %0d, actual %0d",
                           $time, want.external_irq, rsp_external_irq);
                  mismatches++;
               end
               if (rsp_pending_view !== want.pending_view) begin
                  $display("%0t: pending_view expected %h, actual %h",
                           $time, want.pending_view, rsp_pending_view);
                  mismatches++;
               end
            end
         end
      end
      error_count     <= mismatches;
      words_in_flight <= expected_words.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the interrupt priority controller testbench: clock, reset, stimulus and verdict.
module tb_top;
   import ipc_pkg::*;

   localparam int NUM_SRC = NUM_SOURCES_DEF;
   localparam int PRI_W   = PRIORITY_BITS_DEF;
   localparam int SRC_W   = NUM_SRC + 1;
   localparam int ID_W    = $clog2(NUM_SRC + 1);
   localparam int PT_W    = NUM_SRC * PRI_W;
   localparam int CSR_W   = (PT_W > SRC_W) ? PT_W : SRC_W;

   // Codes the package leaves unnamed; the controller must ignore both.
   localparam logic [OP_W-1:0]      OP_RESERVED = 2'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPARE   = 2'd3;

   localparam int RANDOM_WORDS   = 1900;
   localparam int PHASES         = 8;
   localparam int PRESSURE_WORDS = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 200000;

   // Source n gets priority n mod 8, so levels differ and source 8 never fires.
   localparam logic [PT_W-1:0] GRADED_PRIORITY = {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0,
                                                  3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1};

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_operation    = OP_NONE;
   logic [SRC_W-1:0]     req_source_lines = '0;
   logic [CID_W-1:0]     req_complete_id  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [ID_W-1:0]      rsp_claim_id;
   logic                 rsp_external_irq;
   logic [SRC_W-1:0]     rsp_pending_view;
   logic                 csr_write_en     = 1'b0;
   logic [REG_IDX_W-1:0] csr_index        = REG_PRIORITY;
   logic [CSR_W-1:0]     csr_wdata        = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_asked         = 0;
   int hold_granted       = 0;
   int hold_left          = 0;
   int cycle_count        = 0;
   int error_count;
   int words_in_flight;

   interrupt_priority_controller #(
      .NUM_SOURCES   (NUM_SRC),
      .PRIORITY_BITS (PRI_W)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_source_lines (req_source_lines),
      .req_complete_id  (req_complete_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_claim_id     (rsp_claim_id),
      .rsp_external_irq (rsp_external_irq),
      .rsp_pending_view (rsp_pending_view),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   ipc_checker #(
      .NUM_SRC (NUM_SRC),
      .PRI_W   (PRI_W)
   ) u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_source_lines (req_source_lines),
      .req_complete_id  (req_complete_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_claim_id     (rsp_claim_id),
      .rsp_external_irq (rsp_external_irq),
      .rsp_pending_view (rsp_pending_view),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .words_in_flight  (words_in_flight)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response side: random stalls, plus a long hold-off whenever the stimulus asks for one.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_granted) begin
         hold_granted <= hold_asked;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Offer one request word, idling first at random, and return once it is accepted.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] lines,
                            input logic [CID_W-1:0] cid);
      logic took;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_source_lines <= lines;
      req_complete_id  <= cid;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
   endtask

   // Random word: mostly claims and completions of real source IDs, some noise.
   task automatic send_random_word();
      logic [OP_W-1:0]  op;
      logic [SRC_W-1:0] lines;
      logic [CID_W-1:0] cid;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)       op = OP_NONE;
      else if (pick < 12) op = OP_RESERVED;
      else if (pick < 56) op = OP_CLAIM;
      else                op = OP_COMPLETE;
      pick = $urandom_range(0, 99);
      if (pick < 85) cid = CID_W'($urandom_range(1, NUM_SRC));
      else           cid = CID_W'($urandom_range(0, 31));
      // Sparse source activity keeps the pending set from saturating.
      pick = $urandom_range(0, 99);
      if (pick < 50)      lines = SRC_W'(1) << $urandom_range(0, NUM_SRC);
      else if (pick < 70) lines = SRC_W'($urandom);
      else                lines = '0;
      send_word(op, lines, cid);
   endtask

   // Stop offering words, wait until every response is back, then let the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_in_flight != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [PT_W-1:0] prio, input logic [SRC_W-1:0] en,
                               input logic [PRI_W-1:0] th);
      write_reg(REG_PRIORITY, CSR_W'(prio));
      write_reg(REG_ENABLE, CSR_W'(en));
      write_reg(REG_THRESHOLD, CSR_W'(th));
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int phase;
      int i;
      int words_per_phase;
      logic [PT_W-1:0]  prio;
      logic [SRC_W-1:0] en;
      logic [PRI_W-1:0] th;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // With registers at reset nothing may be claimed, but every line still goes pending.
      send_word(OP_CLAIM, '1, '0);
      settle();

      // All priorities equal: claims go out in ID order; bad completion IDs are ignored.
      program_regs('1, '1, '0);
      send_word(OP_CLAIM, '0, '0);
      send_word(OP_CLAIM, '0, '0);
      send_word(OP_COMPLETE, '0, CID_W'(1));
      send_word(OP_COMPLETE, '0, CID_W'(0));
      send_word(OP_COMPLETE, '0, CID_W'(NUM_SRC + 1));
      send_word(OP_COMPLETE, '0, '1);
      send_word(OP_RESERVED, '1, '0);
      // Source 2 is completed while its line is high: it must not pend in the same word.
      send_word(OP_COMPLETE, SRC_W'(1) << 2, CID_W'(2));
      send_word(OP_NONE, '0, '0);
      send_word(OP_CLAIM, SRC_W'(1) << 2, '0);
      settle();

      // Top threshold masks every source.
      write_reg(REG_THRESHOLD, CSR_W'(3'd7));
      csr_write_en <= 1'b0;
      send_word(OP_CLAIM, '1, '0);
      settle();

      // Graded priorities with half the sources disabled.
      program_regs(GRADED_PRIORITY, SRC_W'(15'h5555), 3'd3);
      send_word(OP_CLAIM, '1, '0);
      send_word(OP_COMPLETE, '0, CID_W'(2));
      send_word(OP_COMPLETE, '0, CID_W'(NUM_SRC));
      send_word(OP_CLAIM, '0, '0);
      settle();

      // Nothing enabled; the spare register index must have no effect.
      program_regs(GRADED_PRIORITY, '0, '0);
      write_reg(REG_SPARE, '1);
      csr_write_en <= 1'b0;
      send_word(OP_CLAIM, '1, '0);
      send_word(OP_COMPLETE, '0, CID_W'(1));
      settle();

      // Random traffic over several register settings and idling patterns.
      words_per_phase = RANDOM_WORDS / PHASES;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
            1: begin sender_idle_pct = 64; receiver_stall_pct <= 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct <= 64; end
            default: begin sender_idle_pct = 30; receiver_stall_pct <= 30; end
         endcase
         prio = PT_W'({$urandom, $urandom});
         en   = SRC_W'($urandom) | SRC_W'($urandom);
         th   = PRI_W'($urandom_range(0, 4));
         case (phase)
            0: begin en = '1; th = '0; end
            1: begin prio = '1; th = 3'd6; end
            2: th = PRI_W'($urandom_range(0, 7));
            3: en = '1;
            default: ;
         endcase
         program_regs(prio, en, th);
         for (i = 0; i < words_per_phase; i++)
            send_random_word();
         // Long receiver hold-off while the sender keeps offering, so the input backs up.
         if (phase == 3) begin
            sender_idle_pct = 0;
            hold_asked <= hold_asked + 1;
            for (i = 0; i < PRESSURE_WORDS; i++)
               send_random_word();
         end
         settle();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== interrupt_priority_controller.f =====
rtl/ipc_pkg.sv
rtl/interrupt_priority_controller.sv
dv/ipc_checker.sv
dv/tb_top.sv
